### rtl/spi_master_shift_engine_unit_macros.svh
// Assertion helpers for the shift engine RTL.
`ifndef SPI_MASTER_SHIFT_ENGINE_UNIT_MACROS_SVH
`define SPI_MASTER_SHIFT_ENGINE_UNIT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define SPI_MSE_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a result in the next cycle.
`define SPI_MSE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/spi_mse_pkg.sv
package spi_mse_pkg;

    localparam int DATA_BITS = 8;
    localparam int EDGE_LAST = 2 * DATA_BITS;
    localparam int EDGE_W    = $clog2(EDGE_LAST + 1);
    localparam int PRE_W     = 6;
    localparam int HALF_W    = PRE_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 2;

    typedef logic [DATA_BITS-1:0] word_t;
    typedef logic [EDGE_W-1:0]    edge_cnt_t;
    typedef logic [PRE_W-1:0]     pre_cnt_t;
    typedef logic [HALF_W-1:0]    half_t;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_WRITE_DATA = 2'd1,
        REQ_READ_DATA  = 2'd2,
        REQ_WRITE_STAT = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_LSB_FIRST = 3'd1,
        CFG_POLARITY  = 3'd2,
        CFG_PHASE     = 3'd3,
        CFG_DIVIDER   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_data;
        logic       miso_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_flag;
        logic       collision_flag;
        logic       busy_res;
        logic       sclk_out;
        logic       mosi_out;
    } out_item_t;

    // Half bit period in ticks.
    function automatic half_t half_ticks(input logic [1:0] sel);
        half_t h;
        case (sel)
            2'd0:    h = half_t'(2);
            2'd1:    h = half_t'(8);
            2'd2:    h = half_t'(32);
            2'd3:    h = half_t'(64);
            default: h = half_t'(2);
        endcase
        return h;
    endfunction

    function automatic logic lead_bit(input word_t w, input logic lsb);
        return lsb ? w[0] : w[DATA_BITS-1];
    endfunction

    function automatic word_t shift_in(input word_t w, input logic lsb, input logic b);
        return lsb ? {b, w[DATA_BITS-1:1]} : {w[DATA_BITS-2:0], b};
    endfunction

endpackage

### rtl/spi_master_shift_engine_unit.sv
// Channel  | Direction | Payload     | Handshake
// ---------+-----------+-------------+-----------------------------------
// in       | in        | in_item_t   | in_valid / in_stall (stall driven here)
// out      | out       | out_item_t  | out_valid / out_stall (stall from sink)
// cfg      | in        | cfg_data    | cfg_we, cfg_index, no wait
//
// One item per cycle while in_stall is low: each accepted item updates the state
// and the result register in the same cycle; out_item shows it the next cycle.
// in_stall is high only while the result register is full and out_stall holds it.
// rst_n is asynchronous, active low; it clears all control state and flags.
// A stalled result holds its value until taken.
`include "spi_master_shift_engine_unit_macros.svh"

module spi_master_shift_engine_unit
    import spi_mse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic       enable_reg, enable_next;
    logic       lsb_reg, lsb_next;
    logic       polarity_reg, polarity_next;
    logic       phase_reg, phase_next;
    logic [1:0] divider_reg, divider_next;

    word_t      shift_reg, shift_next;
    word_t      hold_reg, hold_next;
    edge_cnt_t  edge_count_reg, edge_count_next;
    pre_cnt_t   prescale_reg, prescale_next;
    logic       active_reg, active_next;
    logic       done_reg, done_next;
    logic       collision_reg, collision_next;
    logic       sclk_reg, sclk_next;
    logic       mosi_reg, mosi_next;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;

    logic       in_accept;
    half_t      pre_inc;
    edge_cnt_t  edge_inc;
    word_t      sampled;
    logic [7:0] rd;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign pre_inc  = half_t'(prescale_reg) + half_t'(1);
    assign edge_inc = edge_count_reg + edge_cnt_t'(1);
    assign sampled  = shift_in(shift_reg, lsb_reg, in_item.miso_in);

    always_comb
    begin
        enable_next     = enable_reg;
        lsb_next        = lsb_reg;
        polarity_next   = polarity_reg;
        phase_next      = phase_reg;
        divider_next    = divider_reg;
        shift_next      = shift_reg;
        hold_next       = hold_reg;
        edge_count_next = edge_count_reg;
        prescale_next   = prescale_reg;
        active_next     = active_reg;
        done_next       = done_reg;
        collision_next  = collision_reg;
        sclk_next       = sclk_reg;
        mosi_next       = mosi_reg;
        rd              = 8'd0;

        if (in_accept)
        begin
            case (req_t'(in_item.req_type))
                REQ_TICK:
                begin
                    if (active_reg)
                    begin
                        if (pre_inc < half_ticks(divider_reg))
                        begin
                            prescale_next = pre_cnt_t'(pre_inc);
                        end
                        else
                        begin
                            prescale_next   = '0;
                            sclk_next       = !sclk_reg;
                            edge_count_next = edge_inc;
                            // odd edges sample in mode 0, even edges in mode 1
                            if (edge_inc[0] != phase_reg)
                            begin
                                shift_next = sampled;
                            end
                            else if (edge_inc < edge_cnt_t'(EDGE_LAST))
                            begin
                                mosi_next = lead_bit(shift_reg, lsb_reg);
                            end
                            if (edge_inc >= edge_cnt_t'(EDGE_LAST))
                            begin
                                active_next     = 1'b0;
                                done_next       = 1'b1;
                                hold_next       = (edge_inc[0] != phase_reg) ? sampled
                                                                             : shift_reg;
                                sclk_next       = polarity_reg;
                                edge_count_next = '0;
                            end
                        end
                    end
                end
                REQ_WRITE_DATA:
                begin
                    if (enable_reg)
                    begin
                        if (active_reg)
                        begin
                            collision_next = 1'b1;
                        end
                        else
                        begin
                            shift_next      = word_t'(in_item.write_data);
                            active_next     = 1'b1;
                            edge_count_next = '0;
                            prescale_next   = '0;
                            sclk_next       = polarity_reg;
                            if (!phase_reg)
                            begin
                                mosi_next = lead_bit(word_t'(in_item.write_data), lsb_reg);
                            end
                        end
                    end
                end
                REQ_READ_DATA:
                begin
                    rd = 8'(hold_reg);
                end
                REQ_WRITE_STAT:
                begin
                    if (in_item.write_data[0])
                    begin
                        done_next = 1'b0;
                    end
                    if (in_item.write_data[1])
                    begin
                        collision_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    // drop a running transfer
                    if (!cfg_data[0] && active_reg)
                    begin
                        active_next     = 1'b0;
                        edge_count_next = '0;
                        prescale_next   = '0;
                        sclk_next       = polarity_reg;
                    end
                end
                CFG_LSB_FIRST: lsb_next = cfg_data[0];
                CFG_POLARITY:
                begin
                    polarity_next = cfg_data[0];
                    if (!active_reg)
                    begin
                        sclk_next = cfg_data[0];
                    end
                end
                CFG_PHASE:     phase_next   = cfg_data[0];
                CFG_DIVIDER:   divider_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (in_accept)
        begin
            out_valid_next               = 1'b1;
            out_item_next.read_data      = rd;
            out_item_next.done_flag      = done_next;
            out_item_next.collision_flag = collision_next;
            out_item_next.busy_res       = active_next;
            out_item_next.sclk_out       = sclk_next;
            out_item_next.mosi_out       = mosi_next;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            lsb_reg        <= 1'b0;
            polarity_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            divider_reg    <= 2'd0;
            shift_reg      <= '0;
            hold_reg       <= '0;
            edge_count_reg <= '0;
            prescale_reg   <= '0;
            active_reg     <= 1'b0;
            done_reg       <= 1'b0;
            collision_reg  <= 1'b0;
            sclk_reg       <= 1'b0;
            mosi_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            enable_reg     <= enable_next;
            lsb_reg        <= lsb_next;
            polarity_reg   <= polarity_next;
            phase_reg      <= phase_next;
            divider_reg    <= divider_next;
            shift_reg      <= shift_next;
            hold_reg       <= hold_next;
            edge_count_reg <= edge_count_next;
            prescale_reg   <= prescale_next;
            active_reg     <= active_next;
            done_reg       <= done_next;
            collision_reg  <= collision_next;
            sclk_reg       <= sclk_next;
            mosi_reg       <= mosi_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    `SPI_MSE_ASSERT(a_idle_edges_zero, active_reg || (edge_count_reg == '0),
        "edge count not cleared while idle")
    `SPI_MSE_ASSERT(a_edge_in_range, edge_count_reg < edge_cnt_t'(EDGE_LAST),
        "edge count past end of transfer")
    `SPI_MSE_ASSERT(a_idle_clock_level, active_reg || (sclk_reg == polarity_reg),
        "serial clock not at idle level")
    `SPI_MSE_ASSERT_NEXT(a_collision_set,
        in_accept && (in_item.req_type == REQ_WRITE_DATA) && enable_reg && active_reg,
        collision_reg, "write during transfer did not flag collision")

endmodule

### tb/sv/tb.sv
module tb;
    import spi_mse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD = 4;
    localparam int  RESET_CYCLES = 12;
    localparam int  PHASES = 12;
    localparam int  PHASE_ITEMS = 32;
    localparam int  LONG_HOLD = 300;
    localparam int  MAX_LINES = 100;
    localparam int  TIMEOUT_NS = 2_000_000;
    localparam int  HALF_LEN [4] = '{2, 8, 32, 64};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    spi_master_shift_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model of the engine: configuration and state after reset.
    logic      m_en = 1'b0;
    logic      m_lsb = 1'b0;
    logic      m_pol = 1'b0;
    logic      m_pha = 1'b0;
    logic [1:0] m_div = 2'd0;
    word_t     m_shift = '0;
    word_t     m_hold = '0;
    edge_cnt_t m_edges = '0;
    half_t     m_pre = '0;
    logic      m_active = 1'b0;
    logic      m_done = 1'b0;
    logic      m_coll = 1'b0;
    logic      m_sclk = 1'b0;
    logic      m_mosi = 1'b0;

    in_item_t  spi_req_queue[$];
    out_item_t spi_status_due[$];

    int   mismatches = 0;
    int   send_idle_pct = 30;
    int   recv_idle_pct = 61;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;
    int   phase_cnt = 0;
    logic took = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic half_t half_len(input logic [1:0] sel);
        return half_t'(HALF_LEN[sel]);
    endfunction

    function automatic out_item_t spi_next_status(input in_item_t it);
        out_item_t  st;
        logic [7:0] rd;
        half_t      half;
        rd = '0;
        case (it.req_type)
            REQ_TICK: begin
                if (m_active) begin
                    half = half_len(m_div);
                    m_pre = m_pre + 1'b1;
                    if (m_pre >= half) begin
                        m_pre = '0;
                        m_sclk = ~m_sclk;
                        m_edges = m_edges + 1'b1;
                        if (m_edges[0] != m_pha)
                            m_shift = m_lsb ? {it.miso_in, m_shift[DATA_BITS-1:1]}
                                            : {m_shift[DATA_BITS-2:0], it.miso_in};
                        else if (m_edges < EDGE_LAST)
                            m_mosi = m_lsb ? m_shift[0] : m_shift[DATA_BITS-1];
                        if (m_edges >= EDGE_LAST)
                        begin
                            m_active = 1'b0;
                            m_done = 1'b1;
                            m_hold = m_shift;
                            m_sclk = m_pol;
                            m_edges = '0;
                        end
                    end
                end
            end
            REQ_WRITE_DATA: begin
                if (m_en) begin
                    if (m_active)
                        m_coll = 1'b1;
                    else
                    begin
                        m_shift = word_t'(it.write_data);
                        m_active = 1'b1;
                        m_edges = '0;
                        m_pre = '0;
                        m_sclk = m_pol;
                        if (!m_pha)
                            m_mosi = m_lsb ? m_shift[0] : m_shift[DATA_BITS-1];
                    end
                end
            end
            REQ_READ_DATA: rd = m_hold[7:0];
            default: begin
                if (it.write_data[0])
                    m_done = 1'b0;
                if (it.write_data[1])
                    m_coll = 1'b0;
            end
        endcase
        st.read_data = rd;
        st.done_flag = m_done;
        st.collision_flag = m_coll;
        st.busy_res = m_active;
        st.sclk_out = m_sclk;
        st.mosi_out = m_mosi;
        return st;
    endfunction

    function automatic void spi_apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] v);
        case (idx)
            CFG_ENABLE: begin
                m_en = v[0];
                // abort: clock back to idle, no done
                if (!m_en && m_active)
                begin
                    m_active = 1'b0;
                    m_edges = '0;
                    m_pre = '0;
                    m_sclk = m_pol;
                end
            end
            CFG_LSB_FIRST: m_lsb = v[0];
            CFG_POLARITY: begin
                m_pol = v[0];
                if (!m_active)
                    m_sclk = m_pol;
            end
            CFG_PHASE: m_pha = v[0];
            CFG_DIVIDER: m_div = v;
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (mismatches < MAX_LINES)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Check results, then predict the item taken at this edge.
    always @(posedge clk)
    begin
        out_item_t want;
        took = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
                spi_apply_reg(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                if (spi_status_due.size() == 0)
                    flag_mismatch("result with nothing pending", out_item.read_data, 8'h00);
                else
                begin
                    want = spi_status_due.pop_front();
                    if (out_item.read_data !== want.read_data)
                        flag_mismatch("read_data", out_item.read_data, want.read_data);
                    if (out_item.done_flag !== want.done_flag)
                        flag_mismatch("done_flag", 8'(out_item.done_flag),
                                      8'(want.done_flag));
                    if (out_item.collision_flag !== want.collision_flag)
                        flag_mismatch("collision_flag", 8'(out_item.collision_flag),
                                      8'(want.collision_flag));
                    if (out_item.busy_res !== want.busy_res)
                        flag_mismatch("busy_res", 8'(out_item.busy_res),
                                      8'(want.busy_res));
                    if (out_item.sclk_out !== want.sclk_out)
                        flag_mismatch("sclk_out", 8'(out_item.sclk_out),
                                      8'(want.sclk_out));
                    if (out_item.mosi_out !== want.mosi_out)
                        flag_mismatch("mosi_out", 8'(out_item.mosi_out),
                                      8'(want.mosi_out));
                end
            end
            if (in_valid && !in_stall)
            begin
                spi_status_due.push_back(spi_next_status(in_item));
                took = 1'b1;
            end
        end
    end

    // Sender: hold a stalled item, otherwise offer the next one or idle.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || took)
        begin
            if (spi_req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_item <= spi_req_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic in_item_t mk_req(input req_t kind, input logic [7:0] data,
                                        input logic miso);
        in_item_t it;
        it.req_type = kind;
        it.write_data = data;
        it.miso_in = miso;
        return it;
    endfunction

    task automatic offer(input req_t kind, input logic [7:0] data);
        spi_req_queue.push_back(mk_req(kind, data, 1'($urandom)));
        phase_cnt++;
    endtask

    task automatic offer_ticks(input int n);
        for (int i = 0; i < n; i++)
            offer(REQ_TICK, 8'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every item went in and every result came out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (spi_req_queue.size() != 0 || in_valid || spi_status_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // One burst: mostly a full exchange with random content, sometimes noise.
    task automatic build_burst(input logic [1:0] div);
        int n;
        if ($urandom_range(99) < 70)
        begin
            if ($urandom_range(3) == 0)
                offer(REQ_WRITE_STAT, 8'($urandom));
            offer(REQ_WRITE_DATA, 8'($urandom));
            n = 2 * DATA_BITS * HALF_LEN[div] + $urandom_range(3);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(99) < 3)
                    offer(req_t'($urandom_range(3, 1)), 8'($urandom));
                offer(REQ_TICK, 8'($urandom));
            end
            offer(REQ_READ_DATA, 8'($urandom));
        end
        else
        begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                offer(req_t'($urandom_range(3)), 8'($urandom));
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [1:0] div;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Disabled engine: data write ignored, unused mask bits ignored.
        offer(REQ_WRITE_DATA, 8'hA5);
        offer(REQ_READ_DATA, 8'h00);
        offer(REQ_WRITE_STAT, 8'hFC);
        offer(REQ_TICK, 8'hFF);
        wait_drained();
        cfg_write(CFG_UNUSED, 2'b11);
        cfg_write(CFG_DIVIDER, 2'd3);
        cfg_write(CFG_ENABLE, 2'b01);

        // Collision on a busy engine, then a read that leaves flags alone.
        offer(REQ_WRITE_DATA, 8'h00);
        offer(REQ_WRITE_DATA, 8'hFF);
        offer_ticks(70);
        offer(REQ_READ_DATA, 8'h00);
        wait_drained();
        // Shorter divider while busy: the count already passed it.
        cfg_write(CFG_DIVIDER, 2'd0);
        offer_ticks(3);
        offer(REQ_WRITE_STAT, 8'h02);
        wait_drained();
        // Disable mid-transfer: abort.
        cfg_write(CFG_ENABLE, 2'b00);
        offer(REQ_TICK, 8'h00);
        offer(REQ_READ_DATA, 8'h00);
        offer(REQ_WRITE_STAT, 8'hFF);
        wait_drained();
        // Polarity while idle follows at once; while busy it waits.
        cfg_write(CFG_POLARITY, 2'b01);
        cfg_write(CFG_LSB_FIRST, 2'b11);
        cfg_write(CFG_PHASE, 2'b11);
        cfg_write(CFG_ENABLE, 2'b11);
        offer(REQ_WRITE_DATA, 8'h81);
        offer_ticks(5);
        wait_drained();
        cfg_write(CFG_POLARITY, 2'b10);
        offer_ticks(2 * DATA_BITS * HALF_LEN[0]);
        offer(REQ_READ_DATA, 8'h00);
        offer(REQ_WRITE_STAT, 8'h01);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            @(posedge clk);
            if (ph == PHASES / 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 30;
            end
            else if (ph == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0)
            begin
                div = 2'd0;
                cfg_write(CFG_DIVIDER, div);
                cfg_write(CFG_PHASE, 2'b00);
                cfg_write(CFG_POLARITY, 2'b00);
                cfg_write(CFG_LSB_FIRST, 2'b00);
                cfg_write(CFG_ENABLE, 2'b01);
            end
            else if (ph == 1)
            begin
                div = 2'd2;
                cfg_write(CFG_DIVIDER, div);
                cfg_write(CFG_PHASE, 2'b11);
                cfg_write(CFG_POLARITY, 2'b11);
                cfg_write(CFG_LSB_FIRST, 2'b11);
                cfg_write(CFG_ENABLE, 2'b11);
            end
            else
            begin
                div = ($urandom_range(9) < 8) ? 2'd0 : 2'd1;
                cfg_write(CFG_DIVIDER, div);
                cfg_write(CFG_PHASE, 2'($urandom));
                cfg_write(CFG_POLARITY, 2'($urandom));
                cfg_write(CFG_LSB_FIRST, 2'($urandom));
                cfg_write(CFG_ENABLE, {1'($urandom), 1'($urandom_range(9) != 0)});
            end
            phase_cnt = 0;
            while (phase_cnt < PHASE_ITEMS)
                build_burst(div);
            // Starve the output so the block backs up onto its input.
            if (ph == PHASES - 3)
            begin
                @(posedge clk);
                hold_req++;
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
